FILE: rtl/mdce_pkg.sv
package mdce_pkg;

    localparam int BYTE_W    = 8;
    localparam int BUF_LEN_W = 16;
    localparam int OUT_LEN_W = 16;
    localparam int SKIP_W    = 16;
    localparam int ACC_W     = 28;
    localparam int CNT_W     = 3;

    localparam logic [7:0] TAG_ES_DESC       = 8'h03;
    localparam logic [7:0] TAG_DEC_CONFIG    = 8'h04;
    localparam logic [7:0] TAG_DEC_SPECIFIC  = 8'h05;

    // bit positions inside a byte
    localparam int LEN_MORE_BIT  = 7;
    localparam int FLAG_DEP_BIT  = 7;
    localparam int FLAG_URL_BIT  = 6;
    localparam int FLAG_OCR_BIT  = 5;

    localparam logic [SKIP_W-1:0]    DEC_CONFIG_HDR_BYTES = 16'd13;
    localparam logic [SKIP_W-1:0]    DEP_FIELD_BYTES      = 16'd2;
    localparam logic [SKIP_W-1:0]    OCR_FIELD_BYTES      = 16'd2;
    localparam logic [BUF_LEN_W-1:0] MIN_BUFFER_BYTES     = 16'd5;
    localparam logic [CNT_W-1:0]     ES_ID_BYTES          = 3'd2;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic [BYTE_W-1:0]    data;
        logic [OUT_LEN_W-1:0] length;
        logic                 fin;
    } result_t;

endpackage

FILE: rtl/mdce_walker.sv
module mdce_walker
    import mdce_pkg::*;
#(
    parameter int LENGTH_BITS      = 16,
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [BYTE_W-1:0]    byte_value,
    input  logic [BUF_LEN_W-1:0] buffer_length,
    output result_t              res
);

    localparam int NEXT_W = LENGTH_BITS + 1;
    localparam int CMP_W  = (NEXT_W > BUF_LEN_W) ? NEXT_W : BUF_LEN_W;
    localparam int SUM_W  = ((NEXT_W > ACC_W) ? NEXT_W : ACC_W) + 1;

    typedef enum logic [3:0] {
        PH_FIRST, PH_TAG, PH_LEN, PH_ESID, PH_ESFLAGS, PH_DEPSKIP,
        PH_URLLEN, PH_SKIP, PH_PAYLOAD, PH_DONE, PH_SENT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             tag_reg, tag_next;
    logic [7:0]             flags_reg, flags_next;
    logic [SKIP_W-1:0]      skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] found_reg, found_next;

    logic [NEXT_W-1:0]      next_pos;
    logic                   last;
    logic                   overrun;
    logic                   fin;
    logic [SKIP_W-1:0]      flag_skip;

    assign next_pos = NEXT_W'(pos_reg) + NEXT_W'(1);
    assign last     = CMP_W'(next_pos) >= CMP_W'(buffer_length);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        flags_next = flags_reg;
        skip_next  = skip_reg;
        found_next = found_reg;
        overrun    = 1'b0;
        fin        = 1'b0;
        flag_skip  = '0;
        res        = '0;

        unique case (phase_reg)
            PH_FIRST:
            begin
                if (buffer_length <= MIN_BUFFER_BYTES || byte_value != TAG_ES_DESC)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    tag_next   = byte_value;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_LEN;
                end
            end
            PH_TAG:
            begin
                tag_next   = byte_value;
                acc_next   = '0;
                cnt_next   = '0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                acc_next = {acc_reg[ACC_W-8:0], byte_value[6:0]};
                cnt_next = cnt_reg + CNT_W'(1);
                overrun  = (SUM_W'(next_pos) + SUM_W'(acc_next)) > SUM_W'(buffer_length);
                // keep reading length groups while the continuation bit is set, up to MAX_LENGTH_BYTES
                if (!(byte_value[LEN_MORE_BIT] && cnt_next < CNT_W'(MAX_LENGTH_BYTES)))
                begin
                    if (overrun)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (tag_reg == TAG_DEC_SPECIFIC)
                    begin
                        if (acc_next == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            found_next = LENGTH_BITS'(acc_next);
                            skip_next  = acc_next[SKIP_W-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else if (tag_reg == TAG_ES_DESC)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_ESID;
                    end
                    else if (tag_reg == TAG_DEC_CONFIG)
                    begin
                        skip_next  = DEC_CONFIG_HDR_BYTES;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        skip_next  = acc_next[SKIP_W-1:0];
                        phase_next = (acc_next[SKIP_W-1:0] != '0) ? PH_SKIP : PH_TAG;
                    end
                end
            end
            PH_ESID:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_next >= ES_ID_BYTES)
                begin
                    phase_next = PH_ESFLAGS;
                end
            end
            PH_ESFLAGS:
            begin
                flags_next = byte_value;
                flag_skip  = byte_value[FLAG_DEP_BIT] ? DEP_FIELD_BYTES : '0;
                if (byte_value[FLAG_URL_BIT])
                begin
                    skip_next  = flag_skip;
                    phase_next = (flag_skip != '0) ? PH_DEPSKIP : PH_URLLEN;
                end
                else
                begin
                    skip_next  = flag_skip +
                                 (byte_value[FLAG_OCR_BIT] ? OCR_FIELD_BYTES : '0);
                    phase_next = (skip_next != '0) ? PH_SKIP : PH_TAG;
                end
            end
            PH_DEPSKIP:
            begin
                skip_next = skip_reg - SKIP_W'(1);
                if (skip_next == '0)
                begin
                    phase_next = PH_URLLEN;
                end
            end
            PH_URLLEN:
            begin
                skip_next  = SKIP_W'(byte_value) +
                             (flags_reg[FLAG_OCR_BIT] ? OCR_FIELD_BYTES : '0);
                phase_next = (skip_next != '0) ? PH_SKIP : PH_TAG;
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - SKIP_W'(1);
                if (skip_next == '0)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_PAYLOAD:
            begin
                skip_next  = skip_reg - SKIP_W'(1);
                fin        = (skip_next == '0) || last;
                res.valid  = 1'b1;
                res.kind   = KIND_PAYLOAD;
                res.data   = byte_value;
                res.length = OUT_LEN_W'(found_reg);
                res.fin    = fin;
                phase_next = fin ? PH_SENT : PH_PAYLOAD;
            end
            default:
            begin
            end
        endcase

        // last byte of the buffer: report not-found if nothing went out, then clear
        if (last)
        begin
            if (!res.valid && phase_next != PH_SENT)
            begin
                res.valid  = 1'b1;
                res.kind   = KIND_NOT_FOUND;
                res.data   = '0;
                res.length = '0;
                res.fin    = 1'b1;
            end
            phase_next = PH_FIRST;
            pos_next   = '0;
            acc_next   = '0;
            cnt_next   = '0;
            tag_next   = '0;
            flags_next = '0;
            skip_next  = '0;
            found_next = '0;
        end
        else
        begin
            pos_next = next_pos[LENGTH_BITS-1:0];
        end

        if (!step_en)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pos_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            flags_reg <= '0;
            skip_reg  <= '0;
            found_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
            found_reg <= found_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && last) |=> (phase_reg == PH_FIRST && pos_reg == '0))
        else $error("walker state not cleared after last byte");

    a_payload_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (skip_reg != '0))
        else $error("payload phase with no bytes left");

    a_not_found_final: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_NOT_FOUND) |-> (res.fin && res.length == '0))
        else $error("not-found result must be final and empty");

    a_result_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> step_en)
        else $error("result produced without a step");

endmodule

FILE: rtl/mpeg4_descriptor_config_extractor.sv
// MPEG-4 descriptor walker: extracts the decoder-specific-info payload.
//
// Input stream (s_*): one byte of a codec configuration buffer per transfer,
// each carrying the buffer's total length. The buffer ends on the byte whose
// position reaches that length; the next transfer starts a new buffer.
// Output stream (m_*): the payload bytes of the first decoder-specific-info
// descriptor, each with the payload length, tlast on the final one; or a
// single not-found result (tuser = 1, tlast = 1) on the buffer's last byte.
//
// Stages: two register stages (input register, then the parse step into the
// output register); a byte's result is loaded into the output register by
// the step that takes that byte from the input register.
// Throughput: one byte per cycle while not stalled; the whole parse step for a
// byte is one pass of combinational logic between input and output registers.
// A stalled receiver holds the output register; the input register then
// fills and s_tready drops until m_tready returns. No byte is dropped.
// Reset clears the parser to expect the first tag of a new buffer and
// empties both registers.
module mpeg4_descriptor_config_extractor
    import mdce_pkg::*;
#(
    parameter int LENGTH_BITS      = 16,
    parameter int MAX_LENGTH_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // byte_value[7:0], buffer_length[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte[7:0], payload_length[23:8]
    output logic [0:0]  m_tuser,   // result_kind[0]
    output logic        m_tlast
);

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic [BUF_LEN_W-1:0] in_len_reg;
    logic                 advance;

    result_t              res;
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic                 out_fin_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[23:8];
        end
    end

    mdce_walker #(
        .LENGTH_BITS      (LENGTH_BITS),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .byte_value    (in_byte_reg),
        .buffer_length (in_len_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // load payload only with a real result so a held transfer stays intact
    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.data;
            out_len_reg  <= res.length;
            out_fin_reg  <= res.fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_fin_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while output register is empty");

    a_step_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!out_valid_reg || m_tready))
        else $error("step would overwrite a pending result");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("pending result changed while stalled");

endmodule
